// ----- rtl/lqpa_pkg.sv -----
// Shared types, codes and defaults for the least-used queue pool assigner.
package lqpa_pkg;

    localparam int P_PRIORITIES = 4;
    localparam int P_SLOTS      = 8;
    localparam int P_HANDLES    = 64;

    localparam int P_HANDLE_MAX = 64;
    localparam int P_GROUP      = 8;

    localparam int LIMIT_W  = 4;
    localparam int USERS_W  = 7;
    localparam int HANDLE_W = 6;
    localparam int SLOT_W   = 3;

    localparam logic [LIMIT_W-1:0] P_QLIMIT_RST = 4'd8;
    localparam logic [USERS_W-1:0] USER_MAX     = 7'd127;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CHECK   = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_RES     = 2'd1,
        STAT_BAD_HANDLE = 2'd2
    } t_status;

    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            priority_req;
        logic [HANDLE_W-1:0]   handle_in;
        logic                  create_ok;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle_out;
        logic [SLOT_W-1:0]     queue_slot;
        logic                  handle_live;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_AQ_DEC,
        S_AQ_SCAN,
        S_AQ_UPD,
        S_REL_TGT,
        S_REL_UPD
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_all;
        logic chk_commit;
        logic tgt_read;
        logic usr_read_tgt;
        logic rel_commit;
        logic acq_init;
        logic acq_step;
        logic acq_commit;
        logic acq_reject;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  acq_ok;
        logic  scan_done;
    } t_sts;

endpackage

// ----- rtl/lqpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lqpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lqpa_ctrl.sv -----
// Sequencing state machine for the queue pool assigner.
module lqpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lqpa_pkg::t_sts i_sts,
    output lqpa_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    lqpa_pkg::t_state r_state;
    lqpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lqpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            lqpa_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lqpa_pkg::S_PREP;
                end
            end
            lqpa_pkg::S_PREP: begin
                case (i_sts.mode)
                    lqpa_pkg::MODE_ACQUIRE: begin
                        n_state = lqpa_pkg::S_AQ_DEC;
                    end
                    lqpa_pkg::MODE_RELEASE: begin
                        o_cmd.tgt_read = 1'b1;
                        n_state        = lqpa_pkg::S_REL_TGT;
                    end
                    lqpa_pkg::MODE_CHECK: begin
                        o_cmd.chk_commit = 1'b1;
                        n_state          = lqpa_pkg::S_IDLE;
                    end
                    default: begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = lqpa_pkg::S_IDLE;
                    end
                endcase
            end
            lqpa_pkg::S_AQ_DEC: begin
                if (i_sts.acq_ok) begin
                    o_cmd.acq_init = 1'b1;
                    n_state        = lqpa_pkg::S_AQ_SCAN;
                end else begin
                    o_cmd.acq_reject = 1'b1;
                    n_state          = lqpa_pkg::S_IDLE;
                end
            end
            lqpa_pkg::S_AQ_SCAN: begin
                o_cmd.acq_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = lqpa_pkg::S_AQ_UPD;
                end
            end
            lqpa_pkg::S_AQ_UPD: begin
                o_cmd.acq_commit = 1'b1;
                n_state          = lqpa_pkg::S_IDLE;
            end
            lqpa_pkg::S_REL_TGT: begin
                o_cmd.usr_read_tgt = 1'b1;
                n_state            = lqpa_pkg::S_REL_UPD;
            end
            lqpa_pkg::S_REL_UPD: begin
                o_cmd.rel_commit = 1'b1;
                n_state          = lqpa_pkg::S_IDLE;
            end
            default: begin
                n_state = lqpa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != lqpa_pkg::S_IDLE);

endmodule

// ----- rtl/lqpa_dp.sv -----
// Datapath: pool fill, use counts, handle table, free-handle search and slot scan.
module lqpa_dp #(
    parameter int PRIORITIES = lqpa_pkg::P_PRIORITIES,
    parameter int SLOTS      = lqpa_pkg::P_SLOTS,
    parameter int HANDLES    = lqpa_pkg::P_HANDLES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lqpa_pkg::t_cmd                 i_cmd,
    output lqpa_pkg::t_sts                 o_sts,
    input  lqpa_pkg::t_req                 i_req,
    input  logic                           i_cfg_we,
    input  logic [lqpa_pkg::LIMIT_W-1:0]   i_cfg_data,
    output lqpa_pkg::t_res                 o_res,
    output logic                           o_res_valid
);

    localparam int SPAN = (HANDLES < lqpa_pkg::P_HANDLE_MAX) ? HANDLES
                                                              : lqpa_pkg::P_HANDLE_MAX;
    localparam int HW   = $clog2(SPAN);
    localparam int GB   = lqpa_pkg::P_GROUP;
    localparam int GW   = $clog2(GB);
    localparam int NG   = (SPAN + GB - 1) / GB;
    localparam int PIW  = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int UD   = PRIORITIES * SLOTS;
    localparam int UW   = (UD > 1) ? $clog2(UD) : 1;
    localparam int TW   = PIW + SW;
    localparam int UCW  = lqpa_pkg::USERS_W;

    function automatic logic [UW-1:0] f_uaddr(input logic [PIW-1:0] p,
                                              input logic [SW-1:0] s);
        return UW'(32'(p) * SLOTS + 32'(s));
    endfunction

    // request and config
    lqpa_pkg::t_req               r_req;
    logic [lqpa_pkg::LIMIT_W-1:0] r_qlimit;

    // state stores
    logic [CW-1:0]  r_fill [PRIORITIES];
    logic [UD-1:0]  r_uvalid;
    logic [SPAN-1:0] r_used;
    logic           r_rd_uv;

    // free handle search pipeline
    logic [NG-1:0]  r_gfree;
    logic [GW-1:0]  r_gidx [NG];
    logic [NG-1:0]  n_gfree;
    logic [GW-1:0]  n_gidx [NG];
    logic           r_free_ok;
    logic [HW-1:0]  r_free_h;
    logic           n_free_ok;
    logic [HW-1:0]  n_free_h;

    // scan
    logic           r_open;
    logic [CW-1:0]  r_cmp;
    logic [CW-1:0]  r_iss;
    logic [CW-1:0]  r_hi;
    logic [UCW:0]   r_best;
    logic [SW-1:0]  r_slot;

    // result
    lqpa_pkg::t_res r_res;
    lqpa_pkg::t_res n_res;
    logic           r_res_valid;
    logic           n_res_valid;

    // decode
    logic [PIW-1:0] pi;
    logic           prio_ok;
    logic [CW-1:0]  fill;
    logic           open;
    logic [HW-1:0]  hidx;
    logic           hin_ok;
    logic           rel_ok;
    logic [CW-1:0]  lo;
    logic [CW-1:0]  hi;

    // memories
    logic           usr_we;
    logic [UW-1:0]  usr_waddr;
    logic [UCW-1:0] usr_wdata;
    logic           usr_re;
    logic [UW-1:0]  usr_raddr;
    logic [UCW-1:0] usr_rdata;
    logic [UCW-1:0] u_rd;
    logic [UCW-1:0] u_inc;
    logic [UCW-1:0] u_dec;
    logic [TW-1:0]  tgt_rdata;
    logic [PIW-1:0] tgt_p;
    logic [SW-1:0]  tgt_s;
    logic [UW-1:0]  tgt_uaddr;
    logic [UW-1:0]  acq_uaddr;

    assign pi      = PIW'(r_req.priority_req);
    assign prio_ok = (32'(r_req.priority_req) < PRIORITIES);
    assign fill    = r_fill[pi];
    assign open    = (32'(fill) < 32'(r_qlimit)) && (32'(fill) < SLOTS);
    assign hidx    = HW'(r_req.handle_in);
    assign hin_ok  = (32'(r_req.handle_in) < SPAN);
    assign rel_ok  = hin_ok && r_used[hidx];
    assign lo      = open ? fill : '0;
    assign hi      = open ? CW'(fill + CW'(1)) : fill;

    assign o_sts.mode      = r_req.mode;
    assign o_sts.acq_ok    = r_free_ok && prio_ok && (open ? r_req.create_ok : (fill != '0));
    assign o_sts.scan_done = (CW'(r_cmp + CW'(1)) == r_hi);

    assign tgt_p     = tgt_rdata[TW-1:SW];
    assign tgt_s     = tgt_rdata[SW-1:0];
    assign tgt_uaddr = f_uaddr(tgt_p, tgt_s);
    assign acq_uaddr = f_uaddr(pi, r_slot);

    assign u_rd  = r_rd_uv ? usr_rdata : '0;
    assign u_inc = (r_best[UCW-1:0] == lqpa_pkg::USER_MAX) ? lqpa_pkg::USER_MAX
                                                            : UCW'(r_best[UCW-1:0] + 1'b1);
    assign u_dec = (u_rd == '0) ? '0 : UCW'(u_rd - 1'b1);

    always_comb begin
        usr_re    = 1'b0;
        usr_raddr = tgt_uaddr;
        if (i_cmd.acq_init) begin
            usr_re    = 1'b1;
            usr_raddr = f_uaddr(pi, SW'(lo));
        end else if (i_cmd.acq_step) begin
            usr_re    = (r_iss < r_hi);
            usr_raddr = f_uaddr(pi, SW'(r_iss));
        end else if (i_cmd.usr_read_tgt) begin
            usr_re    = 1'b1;
        end
        usr_we    = i_cmd.acq_commit || (i_cmd.rel_commit && rel_ok);
        usr_waddr = i_cmd.acq_commit ? acq_uaddr : tgt_uaddr;
        usr_wdata = i_cmd.acq_commit ? u_inc : u_dec;
    end

    lqpa_ram #(
        .WIDTH (UCW),
        .DEPTH (UD)
    ) u_users (
        .i_clk   (i_clk),
        .i_we    (usr_we),
        .i_waddr (usr_waddr),
        .i_wdata (usr_wdata),
        .i_re    (usr_re),
        .i_raddr (usr_raddr),
        .o_rdata (usr_rdata)
    );

    lqpa_ram #(
        .WIDTH (TW),
        .DEPTH (SPAN)
    ) u_target (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acq_commit),
        .i_waddr (r_free_h),
        .i_wdata ({pi, r_slot}),
        .i_re    (i_cmd.tgt_read),
        .i_raddr (hidx),
        .o_rdata (tgt_rdata)
    );

    // lowest free handle, two registered levels
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_gfree[g] = 1'b0;
            n_gidx[g]  = '0;
            for (int j = GB - 1; j >= 0; j--) begin
                if ((g * GB + j < SPAN) && !r_used[HW'(g * GB + j)]) begin
                    n_gfree[g] = 1'b1;
                    n_gidx[g]  = GW'(j);
                end
            end
        end
    end

    always_comb begin
        n_free_ok = 1'b0;
        n_free_h  = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_gfree[g]) begin
                n_free_ok = 1'b1;
                n_free_h  = HW'(32'(g * GB) + 32'(r_gidx[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gfree   <= n_gfree;
        r_gidx    <= n_gidx;
        r_free_ok <= n_free_ok;
        r_free_h  <= n_free_h;
    end

    always_comb begin
        n_res       = '0;
        n_res_valid = 1'b0;
        if (i_cmd.clear_all) begin
            n_res_valid = 1'b1;
        end
        if (i_cmd.chk_commit) begin
            n_res_valid       = 1'b1;
            n_res.handle_live = rel_ok;
        end
        if (i_cmd.rel_commit) begin
            n_res_valid = 1'b1;
            if (rel_ok) begin
                n_res.queue_slot = lqpa_pkg::SLOT_W'(tgt_s);
            end else begin
                n_res.status = lqpa_pkg::STAT_BAD_HANDLE;
            end
        end
        if (i_cmd.acq_reject) begin
            n_res_valid  = 1'b1;
            n_res.status = lqpa_pkg::STAT_NO_RES;
        end
        if (i_cmd.acq_commit) begin
            n_res_valid      = 1'b1;
            n_res.handle_out = lqpa_pkg::HANDLE_W'(r_free_h);
            n_res.queue_slot = lqpa_pkg::SLOT_W'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlimit    <= lqpa_pkg::P_QLIMIT_RST;
            r_uvalid    <= '0;
            r_used      <= '0;
            r_res_valid <= 1'b0;
            for (int p = 0; p < PRIORITIES; p++) begin
                r_fill[p] <= '0;
            end
        end else begin
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_qlimit <= i_cfg_data;
            end
            if (i_cmd.clear_all) begin
                r_uvalid <= '0;
                r_used   <= '0;
                for (int p = 0; p < PRIORITIES; p++) begin
                    r_fill[p] <= '0;
                end
            end
            if (usr_we) begin
                r_uvalid[usr_waddr] <= 1'b1;
            end
            if (i_cmd.acq_commit) begin
                r_used[r_free_h] <= 1'b1;
                if (r_open) begin
                    r_fill[pi] <= CW'(fill + CW'(1));
                end
            end
            if (i_cmd.rel_commit && rel_ok) begin
                r_used[hidx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (usr_re) begin
            r_rd_uv <= r_uvalid[usr_raddr];
        end
        if (n_res_valid) begin
            r_res <= n_res;
        end
        if (i_cmd.acq_init) begin
            r_open <= open;
            r_cmp  <= lo;
            r_iss  <= CW'(lo + CW'(1));
            r_hi   <= hi;
            r_best <= (UCW+1)'(1 << UCW);
        end
        if (i_cmd.acq_step) begin
            r_cmp <= CW'(r_cmp + CW'(1));
            if (r_iss < r_hi) begin
                r_iss <= CW'(r_iss + CW'(1));
            end
            if ({1'b0, u_rd} < r_best) begin
                r_best <= {1'b0, u_rd};
                r_slot <= SW'(r_cmp);
            end
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// ----- rtl/least_used_queue_pool_assigner_core.sv -----
// Top level of the least-used queue pool assigner.
// Acquire: the slot scan reads the new slot alone, or every filled slot of the pool
//   for reuse (one use counter per cycle from the counter RAM); a reject skips the scan.
// Release: handle table read, then counter read-modify-write; check and clear end in prep.
// The result strobe rises the cycle after the last work cycle; a new start is taken then.
// Reset is synchronous, active low; state is clear and queue_limit is 8 right after it.
module least_used_queue_pool_assigner_core #(
    parameter int PRIORITIES = lqpa_pkg::P_PRIORITIES,
    parameter int SLOTS      = lqpa_pkg::P_SLOTS,
    parameter int HANDLES    = lqpa_pkg::P_HANDLES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lqpa_pkg::t_req               i_req,
    output lqpa_pkg::t_res               o_res,
    output logic                         o_res_valid,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lqpa_pkg::LIMIT_W-1:0] i_cfg_data
);

    lqpa_pkg::t_cmd cmd;
    lqpa_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    lqpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lqpa_dp #(
        .PRIORITIES (PRIORITIES),
        .SLOTS      (SLOTS),
        .HANDLES    (HANDLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule
